// ===== src/knpm_pkg.sv =====
`default_nettype none

package knpm_pkg;

    // Fixed field widths of the item and result beats.
    localparam int COORD_W   = 20;
    localparam int ELEM_W    = 11;
    localparam int TAG_W     = 25;
    localparam int OP_W      = 2;
    localparam int OUT_IDX_W = 10;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W + 1;
    localparam int SUM_W     = SQ_W + 1;
    localparam int DIST_W    = 43;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Operation codes carried by an input beat.
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // One stored table entry.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ELEM_W-1:0]  elem;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // Control from the sequencer to the scan datapath.
    typedef struct packed {
        logic start;
        logic rd_valid;
        logic require_label;
    } scan_ctl_t;

endpackage

`default_nettype wire

// ===== src/keyed_nearest_point_match_unit.sv =====
`default_nettype none

// Keyed nearest-point match.
// Input beats (in_valid/in_stall) carry op, pos_x, pos_y, element_id and
// point_tag. A clear beat empties the table and a load beat appends one
// entry; both finish in the cycle they are accepted and give no result.
// A load into a full table is dropped. A query beat starts a scan of the
// stored entries and gives exactly one result beat (out_valid/out_stall)
// with found, nearest_index, nearest_tag and distance_sq.
// A query scans the stored entries: the entry memory has one read port,
// so the scan reads one entry per cycle, followed by a four-stage
// datapath of memory read, difference, square and compare. The next beat
// can be accepted in the same cycle that the result appears.
// While a query is scanning, in_stall is high. A result that the receiver
// stalls stays in the output register; clear and load beats are still
// accepted behind it, and a following query scans but holds its result
// until the output register is free.
// Reset clears the entry count, the label-match register and all valid
// flags; the table contents are not cleared and need no clearing pass.
// The label-match register is written through cfg_write_en/cfg_write_data
// and should be changed only while the block is idle.
module keyed_nearest_point_match_unit #(
    parameter int TABLE_DEPTH = knpm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_write_en,
    input  wire                                 cfg_write_data,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire  [knpm_pkg::OP_W-1:0]           op,
    input  wire  signed [knpm_pkg::COORD_W-1:0] pos_x,
    input  wire  signed [knpm_pkg::COORD_W-1:0] pos_y,
    input  wire  [knpm_pkg::ELEM_W-1:0]         element_id,
    input  wire  signed [knpm_pkg::TAG_W-1:0]   point_tag,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic                                found,
    output logic [knpm_pkg::OUT_IDX_W-1:0]      nearest_index,
    output logic signed [knpm_pkg::TAG_W-1:0]   nearest_tag,
    output logic [knpm_pkg::DIST_W-1:0]         distance_sq
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               scan_idx_reg;
    logic                           rd_valid_reg;
    logic [IDX_W-1:0]               rd_idx_reg;
    logic                           require_label_match_reg;

    logic [knpm_pkg::COORD_W-1:0]   q_x_reg;
    logic [knpm_pkg::COORD_W-1:0]   q_y_reg;
    logic [knpm_pkg::ELEM_W-1:0]    q_elem_reg;
    logic [knpm_pkg::TAG_W-1:0]     q_tag_reg;

    logic                           out_valid_reg;
    logic                           found_reg;
    logic [knpm_pkg::OUT_IDX_W-1:0] index_reg;
    logic [knpm_pkg::TAG_W-1:0]     tag_reg;
    logic [knpm_pkg::DIST_W-1:0]    dist_reg;

    logic                           accept;
    logic                           is_query;
    logic                           wr_en;
    logic                           rd_en;
    logic                           scan_busy;
    logic                           out_free;
    knpm_pkg::entry_t               wr_entry;
    knpm_pkg::entry_t               rd_entry;
    knpm_pkg::scan_ctl_t            ctl;

    logic                           best_found;
    logic [IDX_W-1:0]               best_idx;
    logic [knpm_pkg::TAG_W-1:0]     best_tag;
    logic [knpm_pkg::SUM_W-1:0]     best_dist;
    logic [IDX_W+knpm_pkg::OUT_IDX_W-1:0] idx_wide;

    // Input beats are taken only between queries.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign is_query = (op == knpm_pkg::OP_QUERY);

    // A load writes at the current fill count unless the table is full.
    assign wr_en = accept && (op == knpm_pkg::OP_LOAD) && (count_reg < DEPTH_CNT);
    assign wr_entry.x    = pos_x;
    assign wr_entry.y    = pos_y;
    assign wr_entry.elem = element_id;
    assign wr_entry.tag  = point_tag;

    // One read per cycle while the scan has entries left.
    assign rd_en = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg);

    assign out_free = !out_valid_reg || !out_stall;

    assign ctl.start         = accept && is_query;
    assign ctl.rd_valid      = rd_valid_reg;
    assign ctl.require_label = require_label_match_reg;

    knpm_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    knpm_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .entry      (rd_entry),
        .entry_idx  (rd_idx_reg),
        .q_x        (q_x_reg),
        .q_y        (q_y_reg),
        .q_elem     (q_elem_reg),
        .q_tag      (q_tag_reg),
        .busy       (scan_busy),
        .best_found (best_found),
        .best_idx   (best_idx),
        .best_tag   (best_tag),
        .best_dist  (best_dist)
    );

    // The reported index keeps only its low bits, zero-extended when the
    // table index is narrower than the field.
    assign idx_wide = {{knpm_pkg::OUT_IDX_W{1'b0}}, best_idx};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!rd_en && !scan_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= ST_IDLE;
            count_reg               <= '0;
            scan_idx_reg            <= '0;
            rd_valid_reg            <= 1'b0;
            require_label_match_reg <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;

            if (cfg_write_en)
            begin
                require_label_match_reg <= cfg_write_data;
            end

            if (accept && (op == knpm_pkg::OP_CLEAR))
            begin
                count_reg <= '0;
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (accept && is_query)
            begin
                scan_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end

            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (accept && is_query)
        begin
            q_x_reg    <= pos_x;
            q_y_reg    <= pos_y;
            q_elem_reg <= element_id;
            q_tag_reg  <= point_tag;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            found_reg <= best_found;
            if (best_found)
            begin
                index_reg <= idx_wide[knpm_pkg::OUT_IDX_W-1:0];
                tag_reg   <= best_tag;
                dist_reg  <= {{(knpm_pkg::DIST_W-knpm_pkg::SUM_W){1'b0}}, best_dist};
            end
            else
            begin
                index_reg <= '0;
                tag_reg   <= '1;
                dist_reg  <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign nearest_index = index_reg;
    assign nearest_tag   = tag_reg;
    assign distance_sq   = dist_reg;

    // A result beat only appears right after a scan has finished.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat raised outside the finish state");

    // A search that finds no entry reports the fixed not-found values.
    a_not_found_values: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |->
            (index_reg == '0) && (tag_reg == '1) && (dist_reg == '0))
        else $error("not-found result carries stale fields");

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count beyond table depth");

    // Between queries no read or datapath stage is in flight.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_valid_reg && !scan_busy))
        else $error("scan pipeline busy while idle");

endmodule

`default_nettype wire

// ===== src/knpm_table.sv =====
`default_nettype none

// Entry memory: one write port, one read port with registered read data.
module knpm_table #(
    parameter int TABLE_DEPTH = knpm_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  wire                   clk,
    input  wire                   wr_en,
    input  wire  [IDX_W-1:0]      wr_addr,
    input  wire knpm_pkg::entry_t wr_data,
    input  wire                   rd_en,
    input  wire  [IDX_W-1:0]      rd_addr,
    output knpm_pkg::entry_t      rd_data
);

    knpm_pkg::entry_t mem [TABLE_DEPTH];
    knpm_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/knpm_scan.sv =====
`default_nettype none

// Three-stage datapath: qualify and difference, square, accumulate the best.
module knpm_scan #(
    parameter int TABLE_DEPTH = knpm_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire knpm_pkg::scan_ctl_t           ctl,
    input  wire knpm_pkg::entry_t              entry,
    input  wire  [IDX_W-1:0]                   entry_idx,
    input  wire  [knpm_pkg::COORD_W-1:0]       q_x,
    input  wire  [knpm_pkg::COORD_W-1:0]       q_y,
    input  wire  [knpm_pkg::ELEM_W-1:0]        q_elem,
    input  wire  [knpm_pkg::TAG_W-1:0]         q_tag,
    output logic                               busy,
    output logic                               best_found,
    output logic [IDX_W-1:0]                   best_idx,
    output logic [knpm_pkg::TAG_W-1:0]         best_tag,
    output logic [knpm_pkg::SUM_W-1:0]         best_dist
);

    logic                                s1_valid_reg;
    logic signed [knpm_pkg::DIFF_W-1:0]  s1_dx_reg;
    logic signed [knpm_pkg::DIFF_W-1:0]  s1_dy_reg;
    logic [IDX_W-1:0]                    s1_idx_reg;
    logic [knpm_pkg::TAG_W-1:0]          s1_tag_reg;

    logic                                s2_valid_reg;
    logic [knpm_pkg::SQ_W-1:0]           s2_sqx_reg;
    logic [knpm_pkg::SQ_W-1:0]           s2_sqy_reg;
    logic [IDX_W-1:0]                    s2_idx_reg;
    logic [knpm_pkg::TAG_W-1:0]          s2_tag_reg;

    logic                                found_reg;
    logic [IDX_W-1:0]                    idx_reg;
    logic [knpm_pkg::TAG_W-1:0]          tag_reg;
    logic [knpm_pkg::SUM_W-1:0]          dist_reg;

    logic                                match;
    logic signed [knpm_pkg::DIFF_W-1:0]  dx_next;
    logic signed [knpm_pkg::DIFF_W-1:0]  dy_next;
    logic signed [2*knpm_pkg::DIFF_W-1:0] prod_x;
    logic signed [2*knpm_pkg::DIFF_W-1:0] prod_y;
    logic [knpm_pkg::SUM_W-1:0]          sum;
    logic                                take;

    // An entry qualifies on its element, and on its label when required.
    assign match = (entry.elem == q_elem)
                   && (!ctl.require_label || (entry.tag == q_tag));
    assign dx_next = $signed({entry.x[knpm_pkg::COORD_W-1], entry.x})
                     - $signed({q_x[knpm_pkg::COORD_W-1], q_x});
    assign dy_next = $signed({entry.y[knpm_pkg::COORD_W-1], entry.y})
                     - $signed({q_y[knpm_pkg::COORD_W-1], q_y});

    assign prod_x = s1_dx_reg * s1_dx_reg;
    assign prod_y = s1_dy_reg * s1_dy_reg;

    assign sum  = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
    // Strict compare keeps the earliest entry on a tie.
    assign take = s2_valid_reg && (!found_reg || (sum < dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.rd_valid && match;
            s2_valid_reg <= s1_valid_reg;
            if (ctl.start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx_reg  <= dx_next;
        s1_dy_reg  <= dy_next;
        s1_idx_reg <= entry_idx;
        s1_tag_reg <= entry.tag;
        s2_sqx_reg <= prod_x[knpm_pkg::SQ_W-1:0];
        s2_sqy_reg <= prod_y[knpm_pkg::SQ_W-1:0];
        s2_idx_reg <= s1_idx_reg;
        s2_tag_reg <= s1_tag_reg;
        if (take)
        begin
            idx_reg  <= s2_idx_reg;
            tag_reg  <= s2_tag_reg;
            dist_reg <= sum;
        end
    end

    assign busy       = ctl.rd_valid || s1_valid_reg || s2_valid_reg;
    assign best_found = found_reg;
    assign best_idx   = idx_reg;
    assign best_tag   = tag_reg;
    assign best_dist  = dist_reg;

endmodule

`default_nettype wire
